>>> src/aesd_pkg.sv
// aes128_block_decrypt package: widths, opcodes, inverse s-box and gf helpers
// depends on nothing
package aesd_pkg;

  localparam int unsigned NumRoundsDef = 10;
  localparam int unsigned KeyWordW     = 64;
  localparam int unsigned KeyIdxW      = 5;
  localparam logic        OpDecrypt    = 1'b0;
  localparam logic        OpLoadKey    = 1'b1;

  typedef logic [127:0] blk_t;

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // multiply by a constant from {09,0b,0d,0e}
  function automatic logic [7:0] gmul(input logic [7:0] x, input logic [3:0] y);
    logic [7:0] x2, x4, x8, acc;
    x2  = xtime(x);
    x4  = xtime(x2);
    x8  = xtime(x4);
    acc = (y[0] ? x : 8'h00) ^ (y[1] ? x2 : 8'h00) ^ (y[2] ? x4 : 8'h00) ^ x8;
    return acc;
  endfunction

  // byte n of the state (byte 0 in the top bits)
  function automatic logic [7:0] sbyte(input blk_t s, input int n);
    return s[127 - 8*n -: 8];
  endfunction

  function automatic blk_t inv_shift_sub(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127 - 8*(4*c+r) -: 8] = inv_sbox(sbyte(s, 4*((c + 4 - r) % 4) + r));
    return o;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t o;
    logic [7:0] a, b, d, e;
    for (int c = 0; c < 4; c++) begin
      a = sbyte(s, 4*c);   b = sbyte(s, 4*c+1);
      d = sbyte(s, 4*c+2); e = sbyte(s, 4*c+3);
      o[127 - 8*(4*c)   -: 8] = gmul(a,4'hE) ^ gmul(b,4'hB) ^ gmul(d,4'hD) ^ gmul(e,4'h9);
      o[127 - 8*(4*c+1) -: 8] = gmul(a,4'h9) ^ gmul(b,4'hE) ^ gmul(d,4'hB) ^ gmul(e,4'hD);
      o[127 - 8*(4*c+2) -: 8] = gmul(a,4'hD) ^ gmul(b,4'h9) ^ gmul(d,4'hE) ^ gmul(e,4'hB);
      o[127 - 8*(4*c+3) -: 8] = gmul(a,4'hB) ^ gmul(b,4'hD) ^ gmul(d,4'h9) ^ gmul(e,4'hE);
    end
    return o;
  endfunction

endpackage

>>> src/aes128_block_decrypt.sv
// aes128_block_decrypt: round-unrolled aes inverse cipher pipeline
// depends on aesd_pkg
//
// One decrypt transaction (opcode 0) can enter every clock cycle unless the
// pipeline is stalled. The block is a pipeline of NUM_ROUNDS+2 register
// stages: an input stage that applies the last round key, one stage per
// inverse round (shift rows, s-box, round key, mix columns but for the last
// round), and an output register. Stalls freeze the whole pipeline, and
// in_tready for a decrypt is low only while the output holds an untaken
// result and the last stage holds a block. Load-key transactions (opcode 1)
// write one 64-bit schedule word into flip-flops in the cycle they are
// accepted and give no result; indexes beyond the schedule are dropped.
// Round keys are read at fixed places per stage, so a load-key transaction
// waits at the input until no block in the pipeline still needs a key;
// every decrypt therefore sees the schedule as it stood when that decrypt
// was accepted. Unwritten words read as garbage.
module aes128_block_decrypt
  import aesd_pkg::*;
#(
  parameter int unsigned NUM_ROUNDS = NumRoundsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[0], key_word_index[5:1], key_word[69:6], cipher_high[133:70],
  // cipher_low[197:134], zero pad to 200
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // plain_high[63:0], plain_low[127:64]
  output logic [127:0] out_tdata
);

  localparam int unsigned KeyWords = 2 * (NUM_ROUNDS + 1);
  localparam int unsigned Stages   = NUM_ROUNDS + 1;

  logic [KeyWordW-1:0] rk_r [KeyWords];
  blk_t                stg_r [Stages];
  logic [Stages-1:0]   vld_r;
  logic                out_vld_r;
  blk_t                out_r;

  logic        op;
  logic [KeyIdxW-1:0] kidx;
  logic        acc, adv, out_load;
  logic        key_busy;

  assign op   = in_tdata[0];
  assign kidx = in_tdata[5:1];

  // the pipeline moves when the last stage is empty or the output can take what it holds
  assign out_load  = vld_r[Stages-1] && (!out_vld_r || out_tready);
  assign adv       = !vld_r[Stages-1] || out_load;
  // blocks in stages 0 to Stages-2 still read round keys from the schedule
  assign key_busy  = |vld_r[Stages-2:0];
  // a key write waits until those blocks have left the round stages
  assign in_tready = adv && !(op == OpLoadKey && key_busy);
  assign acc       = in_tvalid && in_tready;

  function automatic blk_t rkey(input int r);
    return {rk_r[2*r], rk_r[2*r+1]};
  endfunction

  // key schedule store
  always_ff @(posedge clk) begin
    if (acc && op == OpLoadKey && 32'(kidx) < KeyWords)
      rk_r[kidx] <= in_tdata[69:6];
  end

  // datapath stages: stage 0 is the initial key add, stage i runs round
  // NUM_ROUNDS-i
  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= {in_tdata[133:70], in_tdata[197:134]} ^ rkey(NUM_ROUNDS);
      for (int i = 1; i < Stages; i++) begin
        if (i == Stages - 1)
          stg_r[i] <= inv_shift_sub(stg_r[i-1]) ^ rkey(0);
        else
          stg_r[i] <= inv_mix(inv_shift_sub(stg_r[i-1]) ^ rkey(NUM_ROUNDS - i));
      end
    end
    if (out_load)
      out_r <= stg_r[Stages-1];
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv)
        vld_r <= {vld_r[Stages-2:0], acc && op == OpDecrypt};
      if (out_load)
        out_vld_r <= 1'b1;
      else if (out_tready)
        out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r[63:0], out_r[127:64]};

endmodule

>>> src/aesd_checker.sv
// aesd_checker: port-level assertions for aes128_block_decrypt, with bind
// depends on aesd_pkg and aes128_block_decrypt ports only
module aesd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [199:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  import aesd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && in_tdata[0] == OpDecrypt |-> in_tready)
    else $error("decrypt blocked with empty output");

  a_ready_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready && in_tdata[0] == OpDecrypt |-> in_tready)
    else $error("decrypt blocked while output drains");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind aes128_block_decrypt aesd_checker u_aesd_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
